### design/jrce_pkg.sv
// shared types and constants for the joystick report change event unit
`timescale 1ns / 1ps

package jrce_pkg;

   localparam int PAD_BYTES   = 5;
   localparam int NUM_BUTTONS = 12;
   localparam int REPORT_BYTES = 8;
   localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   localparam logic [7:0]  PAD_RESET = 8'h0D;
   localparam logic [7:0]  HAT_RESET = 8'hDE;
   localparam logic [15:0] BTN_RESET = 16'h0000;

   typedef enum logic [1:0] {
      EV_PAD  = 2'd0,
      EV_HAT  = 2'd1,
      EV_DOWN = 2'd2,
      EV_UP   = 2'd3
   } event_kind_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic emit;
   } jrce_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pending;
      logic final_event;
   } jrce_status_type;

endpackage

### design/jrce_ctrl.sv
// controller: report intake, event sequencing and result valid
`timescale 1ns / 1ps

module jrce_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  jrce_pkg::jrce_status_type status,
   output jrce_pkg::jrce_cmd_type    cmd
);
   import jrce_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load = (state_ff == ST_IDLE) && req_valid;
      cmd.emit = (state_ff == ST_BUSY) && status.pending && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_BUSY;
               end
            end
            ST_BUSY: begin
               // a report with no change leaves nothing pending
               if (!status.pending) begin
                  state_ff <= ST_IDLE;
               end else if (cmd.emit && status.final_event) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### design/jrce_dp.sv
// datapath: stored report state, change flags and result registers
`timescale 1ns / 1ps

module jrce_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  jrce_pkg::jrce_cmd_type    cmd,
   output jrce_pkg::jrce_status_type status,
   input  logic [7:0]                req_axis_x,
   input  logic [7:0]                req_axis_y,
   input  logic [7:0]                req_axis_z,
   input  logic [7:0]                req_slider,
   input  logic [7:0]                req_axis_rz,
   input  logic [7:0]                req_hat_byte,
   input  logic [7:0]                req_buttons_low,
   input  logic [7:0]                req_buttons_high,
   output logic [1:0]                rsp_event_kind,
   output logic [7:0]                rsp_out_x,
   output logic [7:0]                rsp_out_y,
   output logic [7:0]                rsp_out_z,
   output logic [7:0]                rsp_out_slider,
   output logic [7:0]                rsp_out_rz,
   output logic [3:0]                rsp_hat_position,
   output logic [3:0]                rsp_button_number,
   output logic                      rsp_last
);
   import jrce_pkg::*;

   function automatic logic [BTN_IDX_W-1:0] lowest_set(input logic [NUM_BUTTONS-1:0] m);
      logic [BTN_IDX_W-1:0] idx;
      idx = '0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = BTN_IDX_W'(i);
         end
      end
      return idx;
   endfunction

   logic [7:0]             report [REPORT_BYTES];
   logic [15:0]            buttons;
   logic [3:0]             hat_nibble;
   logic                   pad_differ;

   // stored state of the previous report
   logic [7:0]             prev_pad_ff [PAD_BYTES];
   logic [7:0]             prev_hat_ff;
   logic [15:0]            prev_btn_ff;

   // current report and pending events
   logic [7:0]             cur_x_ff, cur_y_ff, cur_z_ff, cur_slider_ff, cur_rz_ff;
   logic [3:0]             cur_hat_ff;
   logic [NUM_BUTTONS-1:0] cur_btn_ff;
   logic                   pad_pend_ff;
   logic                   hat_pend_ff;
   logic [NUM_BUTTONS-1:0] chg_ff;
   logic [NUM_BUTTONS-1:0] chg_rest;
   logic [BTN_IDX_W-1:0]   btn_idx;

   // result registers
   logic [1:0]             kind_ff;
   logic [7:0]             out_x_ff, out_y_ff, out_z_ff, out_slider_ff, out_rz_ff;
   logic [3:0]             hat_pos_ff;
   logic [3:0]             btn_num_ff;
   logic                   last_ff;

   always_comb begin
      report[0] = req_axis_x;
      report[1] = req_axis_y;
      report[2] = req_axis_z;
      report[3] = req_slider;
      report[4] = req_axis_rz;
      report[5] = req_hat_byte;
      report[6] = req_buttons_low;
      report[7] = req_buttons_high;
      buttons    = {req_buttons_high, req_buttons_low};
      hat_nibble = req_hat_byte[3:0];
      pad_differ = 1'b0;
      for (int i = 0; i < PAD_BYTES; i++) begin
         if (report[i] != prev_pad_ff[i]) begin
            pad_differ = 1'b1;
         end
      end
   end

   always_comb begin
      btn_idx  = lowest_set(chg_ff);
      chg_rest = chg_ff & (chg_ff - NUM_BUTTONS'(1));
      status.pending = pad_pend_ff || hat_pend_ff || (chg_ff != '0);
      if (pad_pend_ff) begin
         status.final_event = !hat_pend_ff && (chg_ff == '0);
      end else if (hat_pend_ff) begin
         status.final_event = (chg_ff == '0);
      end else begin
         status.final_event = (chg_rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAD_BYTES; i++) begin
            prev_pad_ff[i] <= PAD_RESET;
         end
         prev_hat_ff <= HAT_RESET;
         prev_btn_ff <= BTN_RESET;
         pad_pend_ff <= 1'b0;
         hat_pend_ff <= 1'b0;
         chg_ff      <= '0;
      end else if (cmd.load) begin
         // pad bytes are kept only when they changed
         if (pad_differ) begin
            for (int i = 0; i < PAD_BYTES; i++) begin
               prev_pad_ff[i] <= report[i];
            end
         end
         prev_hat_ff <= {4'd0, hat_nibble};
         prev_btn_ff <= buttons;
         pad_pend_ff <= pad_differ;
         hat_pend_ff <= ({4'd0, hat_nibble} != prev_hat_ff);
         chg_ff      <= NUM_BUTTONS'(buttons ^ prev_btn_ff);
      end else if (cmd.emit) begin
         if (pad_pend_ff) begin
            pad_pend_ff <= 1'b0;
         end else if (hat_pend_ff) begin
            hat_pend_ff <= 1'b0;
         end else begin
            chg_ff <= chg_rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff      <= req_axis_x;
         cur_y_ff      <= req_axis_y;
         cur_z_ff      <= req_axis_z;
         cur_slider_ff <= req_slider;
         cur_rz_ff     <= req_axis_rz;
         cur_hat_ff    <= hat_nibble;
         cur_btn_ff    <= NUM_BUTTONS'(buttons);
      end
      if (cmd.emit) begin
         out_x_ff      <= cur_x_ff;
         out_y_ff      <= cur_y_ff;
         out_z_ff      <= cur_z_ff;
         out_slider_ff <= cur_slider_ff;
         out_rz_ff     <= cur_rz_ff;
         last_ff       <= status.final_event;
         if (pad_pend_ff) begin
            kind_ff    <= EV_PAD;
            hat_pos_ff <= 4'd0;
            btn_num_ff <= 4'd0;
         end else if (hat_pend_ff) begin
            kind_ff    <= EV_HAT;
            hat_pos_ff <= cur_hat_ff;
            btn_num_ff <= 4'd0;
         end else begin
            kind_ff    <= cur_btn_ff[btn_idx] ? EV_DOWN : EV_UP;
            hat_pos_ff <= 4'd0;
            btn_num_ff <= 4'(btn_idx) + 4'd1;
         end
      end
   end

   assign rsp_event_kind    = kind_ff;
   assign rsp_out_x         = out_x_ff;
   assign rsp_out_y         = out_y_ff;
   assign rsp_out_z         = out_z_ff;
   assign rsp_out_slider    = out_slider_ff;
   assign rsp_out_rz        = out_rz_ff;
   assign rsp_hat_position  = hat_pos_ff;
   assign rsp_button_number = btn_num_ff;
   assign rsp_last          = last_ff;

endmodule

### design/joystick_report_change_events_unit.sv
// Joystick report change event unit: takes one 8-byte report per transfer and
// emits a pad event if the pad bytes changed, a hat event if the hat nibble
// changed and one event per changed button of the low 12, in that order,
// comparing against the previously stored report. The report is registered,
// then the sequencer sends one event per cycle from the output register while
// the result side does not stall; the next report is taken once the final event
// has been loaded into the output register. rsp_last marks the final event.
`timescale 1ns / 1ps

module joystick_report_change_events_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_axis_x,
   input  logic [7:0] req_axis_y,
   input  logic [7:0] req_axis_z,
   input  logic [7:0] req_slider,
   input  logic [7:0] req_axis_rz,
   input  logic [7:0] req_hat_byte,
   input  logic [7:0] req_buttons_low,
   input  logic [7:0] req_buttons_high,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_kind,
   output logic [7:0] rsp_out_x,
   output logic [7:0] rsp_out_y,
   output logic [7:0] rsp_out_z,
   output logic [7:0] rsp_out_slider,
   output logic [7:0] rsp_out_rz,
   output logic [3:0] rsp_hat_position,
   output logic [3:0] rsp_button_number,
   output logic       rsp_last
);
   import jrce_pkg::*;

   jrce_cmd_type    cmd;
   jrce_status_type status;

   jrce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   jrce_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_axis_x        (req_axis_x),
      .req_axis_y        (req_axis_y),
      .req_axis_z        (req_axis_z),
      .req_slider        (req_slider),
      .req_axis_rz       (req_axis_rz),
      .req_hat_byte      (req_hat_byte),
      .req_buttons_low   (req_buttons_low),
      .req_buttons_high  (req_buttons_high),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_z         (rsp_out_z),
      .rsp_out_slider    (rsp_out_slider),
      .rsp_out_rz        (rsp_out_rz),
      .rsp_hat_position  (rsp_hat_position),
      .rsp_button_number (rsp_button_number),
      .rsp_last          (rsp_last)
   );

endmodule
